/* rtl/button_light_mode_controller_assert.svh */
// Assertion macros used by the button light mode controller core RTL.
`ifndef BUTTON_LIGHT_MODE_CONTROLLER_ASSERT_SVH
`define BUTTON_LIGHT_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BLMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blmc assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define BLMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blmc assertion failed: next-cycle check");

`endif

/* rtl/blmc_pkg.sv */
package blmc_pkg;

    // Elapsed counter width and configuration register width
    localparam int CNT_BITS = 16;
    localparam int CFG_BITS = 16;
    localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

    // Configuration register indexes
    localparam int REG_IDX_BITS = 2;
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_MODE_STEP  = 2'd2
    } t_reg_idx;

    // Lamp patterns
    localparam logic [1:0] PAT_BOTH   = 2'd0;
    localparam logic [1:0] PAT_SECOND = 2'd1;
    localparam logic [1:0] PAT_FIRST  = 2'd2;
    localparam logic [1:0] PAT_NONE   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_BITS-1:0] MODE_STEP_RST  = 16'd2000;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ticks;
        logic [CFG_BITS-1:0] long_press_ticks;
        logic [CFG_BITS-1:0] mode_step_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] lamp_mode;
        logic       button_held;
        logic       setup_active;
        logic       lamp_two;
        logic       lamp_one;
    } t_result;

    // Saturating increment of an elapsed counter
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        sat_inc = (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

/* rtl/blmc_core.sv */
`include "button_light_mode_controller_assert.svh"

module blmc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_level,
    input  blmc_pkg::t_cfg   i_cfg,
    output blmc_pkg::t_result o_result
);
    import blmc_pkg::*;

    logic                r_held;
    logic                r_settling;
    logic [CNT_BITS-1:0] r_since_change;
    logic [CNT_BITS-1:0] r_since_press;
    logic [CNT_BITS-1:0] r_since_step;
    logic                r_lit;
    logic [1:0]          r_pattern;
    logic                r_setup;

    logic                n_held;
    logic                n_settling;
    logic [CNT_BITS-1:0] n_since_change;
    logic [CNT_BITS-1:0] n_since_press;
    logic [CNT_BITS-1:0] n_since_step;
    logic                n_lit;
    logic [1:0]          n_pattern;
    logic                n_setup;

    logic                pressed;
    logic                sample;
    logic                accept_press;

    assign pressed = ~i_level;

    // Debounce gate: pin is ignored while settling and inside the window
    assign sample = !(r_settling &&
                      (CMP_BITS'(n_since_change_inc()) < CMP_BITS'(i_cfg.debounce_ticks)));

    // Debounced press taken on this word
    assign accept_press = i_adv && sample && pressed && !r_held;

    function automatic logic [CNT_BITS-1:0] n_since_change_inc();
        n_since_change_inc = sat_inc(r_since_change);
    endfunction

    // Next state for one tick
    always_comb begin
        n_held         = r_held;
        n_settling     = r_settling;
        n_since_change = sat_inc(r_since_change);
        n_since_press  = sat_inc(r_since_press);
        n_since_step   = sat_inc(r_since_step);
        n_lit          = r_lit;
        n_pattern      = r_pattern;
        n_setup        = r_setup;

        if (sample) begin
            if (pressed != r_held) begin
                if (pressed) begin
                    n_since_press = '0;
                    n_lit         = ~r_lit;
                end else begin
                    n_setup = 1'b0;
                end
                n_held     = pressed;
                n_settling = 1'b1;
            end else begin
                n_settling = 1'b0;
            end
            n_since_change = '0;
        end

        // Long press handling and pattern stepping while held
        if (n_held) begin
            if (n_setup) begin
                if (CMP_BITS'(n_since_step) >= CMP_BITS'(i_cfg.mode_step_ticks)) begin
                    n_since_step = '0;
                    n_pattern    = (r_pattern < PAT_FIRST) ? r_pattern + 2'd1 : PAT_BOTH;
                end
            end else if (CMP_BITS'(n_since_press) > CMP_BITS'(i_cfg.long_press_ticks)) begin
                n_setup = 1'b1;
                n_lit   = 1'b1;
            end
        end
    end

    // Result word from the updated state
    always_comb begin
        o_result.lamp_one     = n_lit && (n_pattern == PAT_BOTH || n_pattern == PAT_FIRST);
        o_result.lamp_two     = n_lit && (n_pattern == PAT_BOTH || n_pattern == PAT_SECOND);
        o_result.setup_active = n_setup;
        o_result.button_held  = n_held;
        o_result.lamp_mode    = n_pattern;
    end

    // State registers, updated once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= 1'b0;
            r_settling     <= 1'b0;
            r_since_change <= '0;
            r_since_press  <= '0;
            r_since_step   <= '0;
            r_lit          <= 1'b0;
            r_pattern      <= PAT_BOTH;
            r_setup        <= 1'b0;
        end else if (i_adv) begin
            r_held         <= n_held;
            r_settling     <= n_settling;
            r_since_change <= n_since_change;
            r_since_press  <= n_since_press;
            r_since_step   <= n_since_step;
            r_lit          <= n_lit;
            r_pattern      <= n_pattern;
            r_setup        <= n_setup;
        end
    end

    // Pattern three is never reached
    `BLMC_ASSERT_NOW(a_pattern_valid, i_clk, i_rst_n, 1'b1, r_pattern != PAT_NONE)
    // Setup mode only exists while the button is held
    `BLMC_ASSERT_NOW(a_setup_held, i_clk, i_rst_n, r_setup, r_held)
    // Setup mode always has the lights on
    `BLMC_ASSERT_NOW(a_setup_lit, i_clk, i_rst_n, r_setup, r_lit)
    // An accepted press restarts the hold timer
    `BLMC_ASSERT_NEXT(a_press_clears, i_clk, i_rst_n, accept_press, r_since_press == '0)

endmodule

/* rtl/button_light_mode_controller.sv */
// Channel  | Direction | Word fields (low bit up)
// ---------+-----------+----------------------------------------------------------
// s_axis   | in        | tdata: [0] button_level, [7:1] zero
// m_axis   | out       | tdata: [0] lamp_one, [1] lamp_two, [2] setup_active,
//          |           |        [3] button_held, [5:4] lamp_mode, [7:6] zero
// cfg      | in        | i_cfg_we, i_cfg_addr (0 debounce, 1 long press, 2 step)
//
// One word per cycle while m_axis is ready; a taken word passes through the input register,
// then the state update writes its result into the result register.
// Synchronous active-low reset clears state, config to defaults, and both valids.
// A stalled m_axis holds its word; s_axis keeps taking words while the input register
// is empty or can drain into the result register in the same cycle.
module button_light_mode_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] button_level, [7:1] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] lamp_one, [1] lamp_two, [2] setup_active,
                                       // [3] button_held, [5:4] lamp_mode, [7:6] zero
    input  logic       i_cfg_we,
    input  logic [blmc_pkg::REG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [blmc_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import blmc_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    adv;

    // Word moves from the input register into the result register
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RST;
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.mode_step_ticks  <= MODE_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_DEBOUNCE:   r_cfg.debounce_ticks   <= i_cfg_wdata;
                REG_LONG_PRESS: r_cfg.long_press_ticks <= i_cfg_wdata;
                REG_MODE_STEP:  r_cfg.mode_step_ticks  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    blmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_level  (r_in_level),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule
